FILE: hw/rtl/mcs_pkg.sv
// Shared types and constants of the min-max channel selector.
`default_nettype none

package mcs_pkg;

  localparam int LevelW      = 8;
  localparam int DefNodes    = 32;
  localparam int DefChannels = 16;

  typedef enum logic [1:0] {
    CmdReport = 2'd0,
    CmdDecide = 2'd1,
    CmdClear  = 2'd2
  } mcs_cmd_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StDone
  } mcs_state_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [4:0]        node_id;
    logic [3:0]        channel;
    logic [LevelW-1:0] level;
    logic              last;
    logic              report_ok;
  } mcs_in_t;

  typedef struct packed {
    logic [3:0]        best_channel;
    logic [LevelW-1:0] best_level;
  } mcs_out_t;

  // Table write request, already range checked.
  typedef struct packed {
    logic              wr_en;
    logic              set_flag;
    logic              flag_val;
    logic              clear_all;
    logic [4:0]        node_id;
    logic [3:0]        channel;
    logic [LevelW-1:0] level;
  } mcs_wr_t;

  // Registered answer to a scan read.
  typedef struct packed {
    logic              node_valid;
    logic [LevelW-1:0] level;
  } mcs_rd_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mcs_table.sv
// Level memory and per-node valid flags of the min-max channel selector.
`default_nettype none

module mcs_table #(
  parameter int NODES    = mcs_pkg::DefNodes,
  parameter int CHANNELS = mcs_pkg::DefChannels
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mcs_pkg::mcs_wr_t            wr_i,
  input  logic                        rd_en_i,
  input  logic [$clog2(NODES)-1:0]    rd_node_i,
  input  logic [$clog2(CHANNELS)-1:0] rd_chan_i,
  output mcs_pkg::mcs_rd_rsp_t        rd_rsp_o
);
  import mcs_pkg::*;

  localparam int NodeW = $clog2(NODES);
  localparam int ChanW = $clog2(CHANNELS);
  localparam int Depth = 1 << (NodeW + ChanW);

  logic [LevelW-1:0] mem [Depth];
  logic [NODES-1:0]  node_valid_q;
  logic [NodeW-1:0]  wr_node;
  logic [ChanW-1:0]  wr_chan;
  mcs_rd_rsp_t       rsp_q;

  assign wr_node = NodeW'(wr_i.node_id);
  assign wr_chan = ChanW'(wr_i.channel);

  // Entries are addressed as node in the upper bits, channel in the lower bits.
  always_ff @(posedge clk_i) begin
    if (wr_i.wr_en) begin
      mem[{wr_node, wr_chan}] <= wr_i.level;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rsp_q.level      <= mem[{rd_node_i, rd_chan_i}];
      rsp_q.node_valid <= node_valid_q[rd_node_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_valid_q <= '0;
    end else if (wr_i.clear_all) begin
      node_valid_q <= '0;
    end else if (wr_i.set_flag) begin
      node_valid_q[wr_node] <= wr_i.flag_val;
    end
  end

  assign rd_rsp_o = rsp_q;

  // Writes are only taken while idle, so they never meet a scan read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i.wr_en || wr_i.clear_all) |-> !rd_en_i)
    else $error("table written during a scan");

endmodule

`default_nettype wire

FILE: hw/rtl/mcs_scan.sv
// Decide sequencer: walks the level memory and finds the min-max channel.
`default_nettype none

module mcs_scan #(
  parameter int NODES    = mcs_pkg::DefNodes,
  parameter int CHANNELS = mcs_pkg::DefChannels
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        out_free_i,
  input  mcs_pkg::mcs_rd_rsp_t        rd_rsp_i,
  output logic                        rd_en_o,
  output logic [$clog2(NODES)-1:0]    rd_node_o,
  output logic [$clog2(CHANNELS)-1:0] rd_chan_o,
  output logic                        busy_o,
  output logic                        done_o,
  output mcs_pkg::mcs_out_t           result_o
);
  import mcs_pkg::*;

  localparam int NodeW = $clog2(NODES);
  localparam int ChanW = $clog2(CHANNELS);

  mcs_state_e        state_q, state_d;
  logic [NodeW-1:0]  node_q;
  logic [ChanW-1:0]  chan_q;
  logic              last_node, last_chan;
  logic              rd_vld_q, rd_last_q;
  logic [ChanW-1:0]  rd_chan_q;
  logic [LevelW-1:0] worst_q, worst_new, best_lvl_q;
  logic [ChanW-1:0]  best_chan_q;

  assign last_node = (node_q == NodeW'(NODES - 1));
  assign last_chan = (chan_q == ChanW'(CHANNELS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    rd_en_o = 1'b0;
    done_o  = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StScan;
        end
      end
      StScan: begin
        rd_en_o = 1'b1;
        if (last_node && last_chan) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StDone;
      end
      StDone: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Channel-major walk; the counters come back to zero after the last entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q    <= '0;
      chan_q    <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      rd_chan_q <= '0;
    end else begin
      rd_vld_q  <= rd_en_o;
      rd_last_q <= last_node;
      rd_chan_q <= chan_q;
      if (rd_en_o) begin
        if (last_node) begin
          node_q <= '0;
          chan_q <= last_chan ? '0 : chan_q + 1'b1;
        end else begin
          node_q <= node_q + 1'b1;
        end
      end
    end
  end

  assign rd_node_o = node_q;
  assign rd_chan_o = chan_q;

  assign worst_new = (rd_rsp_i.node_valid && (rd_rsp_i.level > worst_q)) ?
                     rd_rsp_i.level : worst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      worst_q <= '0;
    end else if (rd_vld_q) begin
      worst_q <= rd_last_q ? '0 : worst_new;
    end
  end

  // A strict compare keeps the lowest channel on ties.
  always_ff @(posedge clk_i) begin
    if (rd_vld_q && rd_last_q && ((rd_chan_q == '0) || (worst_new < best_lvl_q))) begin
      best_lvl_q  <= worst_new;
      best_chan_q <= rd_chan_q;
    end
  end

  assign busy_o                = (state_q != StIdle);
  assign result_o.best_channel = 4'(best_chan_q);
  assign result_o.best_level   = best_lvl_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !rd_vld_q)
    else $error("read data pending while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain) |-> (rd_vld_q && rd_last_q && (node_q == '0) && (chan_q == '0)))
    else $error("scan did not end on the last entry");

endmodule

`default_nettype wire

FILE: hw/rtl/minmax_channel_selector_top.sv
// Top level of the min-max channel selector.
`default_nettype none

//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+-----------------------------------
//  in      | input     | in_valid_i/in_stall_o | in_item_i (cmd, node, channel, ...)
//  out     | output    | out_valid_o/out_stall_i | out_item_o (best_channel, level)
//
// Report, clear and unused command items are taken one per cycle while no decide runs.
// A decide item holds the input stalled until its result enters the output register:
// the single read port of the level memory is walked once per entry.
// The result is held in an output register until the receiver takes it; a
// further decide cannot deliver while that register is still occupied.
// Reset clears the node valid flags; the level memory has no reset.

module minmax_channel_selector_top #(
  parameter int NODES    = mcs_pkg::DefNodes,
  parameter int CHANNELS = mcs_pkg::DefChannels
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mcs_pkg::mcs_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mcs_pkg::mcs_out_t out_item_o
);
  import mcs_pkg::*;

  localparam int NodeW = $clog2(NODES);
  localparam int ChanW = $clog2(CHANNELS);

  logic             in_accept;
  logic             node_ok, chan_ok;
  logic             start;
  logic             busy, done, out_free;
  mcs_wr_t          wr;
  mcs_rd_rsp_t      rd_rsp;
  logic             rd_en;
  logic [NodeW-1:0] rd_node;
  logic [ChanW-1:0] rd_chan;
  mcs_out_t         result;
  logic             out_valid_q;
  mcs_out_t         out_item_q;

  // While a decide is running the input is held off, so the table never sees
  // a write that could overlap a scan read of the same entry.
  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Report elements for nodes or channels outside the table are dropped whole.
  assign node_ok = int'(in_item_i.node_id) < NODES;
  assign chan_ok = int'(in_item_i.channel) < CHANNELS;

  always_comb begin
    wr.wr_en     = in_accept && (in_item_i.cmd == CmdReport) && node_ok && chan_ok;
    wr.set_flag  = wr.wr_en && in_item_i.last;
    wr.flag_val  = in_item_i.report_ok;
    wr.clear_all = in_accept && (in_item_i.cmd == CmdClear);
    wr.node_id   = in_item_i.node_id;
    wr.channel   = in_item_i.channel;
    wr.level     = in_item_i.level;
  end

  assign start = in_accept && (in_item_i.cmd == CmdDecide);

  mcs_table #(
    .NODES   (NODES),
    .CHANNELS(CHANNELS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_en_i  (rd_en),
    .rd_node_i(rd_node),
    .rd_chan_i(rd_chan),
    .rd_rsp_o (rd_rsp)
  );

  mcs_scan #(
    .NODES   (NODES),
    .CHANNELS(CHANNELS)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .out_free_i(out_free),
    .rd_rsp_i  (rd_rsp),
    .rd_en_o   (rd_en),
    .rd_node_o (rd_node),
    .rd_chan_o (rd_chan),
    .busy_o    (busy),
    .done_o    (done),
    .result_o  (result)
  );

  // The output register may be refilled in the cycle its item is taken.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // An accepted decide always starts the scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy)
    else $error("decide item did not start a scan");

  // A waiting result is never overwritten by the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && out_valid_q) |-> !out_stall_i)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire
